FILE: rtl/bad_pkg.sv
// Shared constants and types for the box average downscaler.
`timescale 1ns / 1ps
package bad_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int SW = 11;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SUMW = 28;
  localparam int AW = 22;
  localparam int QW = 8;

  localparam logic [2:0] REG_IN_WIDTH = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TGT_WIDTH = 3'd2;
  localparam logic [2:0] REG_TGT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ALPHA_MODE = 3'd4;

  typedef struct packed {
    logic restart;
    logic div_start;
    logic clr_start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic clr_done;
  } stat_t;
endpackage

FILE: rtl/bad_if.sv
// Valid/ready stream interfaces for pixels and block averages.
`timescale 1ns / 1ps
interface bad_pix_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic [7:0] pix_alpha;
  modport source (output valid, pix_red, pix_green, pix_blue, pix_alpha, input ready);
  modport sink (input valid, pix_red, pix_green, pix_blue, pix_alpha, output ready);
endinterface

interface bad_avg_if (input logic clk);
  logic valid;
  logic ready;
  logic [7:0] avg_red;
  logic [7:0] avg_green;
  logic [7:0] avg_blue;
  logic [7:0] avg_alpha;
  logic frame_last;
  modport source (output valid, avg_red, avg_green, avg_blue, avg_alpha, frame_last,
                  input ready);
  modport sink (input valid, avg_red, avg_green, avg_blue, avg_alpha, frame_last,
                output ready);
endinterface

FILE: rtl/bad_ctrl.sv
// Controller: sequences block-size division and the sum memory clear.
`timescale 1ns / 1ps
module bad_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  bad_pkg::stat_t stat,
  output bad_pkg::cmd_t cmd,
  output logic run
);
  localparam logic [1:0] S_START = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_CLR = 2'd2;
  localparam logic [1:0] S_RUN = 2'd3;
  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    if (cfg_write) begin
      state_next = S_START;
    end else begin
      unique case (state)
        S_START: begin
          cmd.restart = 1'b1;
          cmd.div_start = 1'b1;
          cmd.clr_start = 1'b1;
          state_next = S_DIV;
        end
        S_DIV: if (stat.div_done) state_next = S_CLR;
        S_CLR: if (stat.clr_done) state_next = S_RUN;
        S_RUN: state_next = S_RUN;
        default: state_next = S_START;
      endcase
    end
  end

  assign run = (state == S_RUN) && !cfg_write;

  always_ff @(posedge clk) begin
    if (rst) state <= S_START;
    else state <= state_next;
  end
endmodule

FILE: rtl/bad_dp.sv
// Datapath: config registers, block-size divider, column sum memory, averaging.
`timescale 1ns / 1ps
module bad_dp (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [bad_pkg::SW-1:0] cfg_data,
  input  bad_pkg::cmd_t cmd,
  output bad_pkg::stat_t stat,
  input  logic run,
  bad_pix_if.sink pix,
  bad_avg_if.source avg
);
  localparam int SW = bad_pkg::SW;
  localparam int CW = bad_pkg::CW;
  localparam int SUMW = bad_pkg::SUMW;
  localparam int AW = bad_pkg::AW;
  localparam int QW = bad_pkg::QW;
  localparam int DEPTH = bad_pkg::MAX_WIDTH;

  logic [SW-1:0] in_width, in_height, target_width, target_height;
  logic alpha_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width <= SW'(1024);
      in_height <= SW'(1024);
      target_width <= SW'(1024);
      target_height <= SW'(1024);
      alpha_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bad_pkg::REG_IN_WIDTH: in_width <= cfg_data;
        bad_pkg::REG_IN_HEIGHT: in_height <= cfg_data;
        bad_pkg::REG_TGT_WIDTH: target_width <= cfg_data;
        bad_pkg::REG_TGT_HEIGHT: target_height <= cfg_data;
        bad_pkg::REG_ALPHA_MODE: alpha_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] iw, ih, tw, th, ow, oh;
  always_comb begin
    iw = (in_width == '0) ? SW'(1) : in_width;
    if (iw > SW'(bad_pkg::MAX_WIDTH)) iw = SW'(bad_pkg::MAX_WIDTH);
    ih = (in_height == '0) ? SW'(1) : in_height;
    if (ih > SW'(bad_pkg::MAX_HEIGHT)) ih = SW'(bad_pkg::MAX_HEIGHT);
    tw = (target_width == '0) ? SW'(1) : target_width;
    th = (target_height == '0) ? SW'(1) : target_height;
    ow = (tw < iw) ? tw : iw;
    oh = (th < ih) ? th : ih;
  end

  // restoring divider, width and height in parallel, one bit a cycle
  logic [SW-1:0] qw, qh, rw, rh, nw, nh;
  logic [$clog2(SW+1)-1:0] dcnt;
  logic dbusy;
  logic div_done, clr_done;
  logic [SW:0] rws, rhs;
  assign rws = {rw, nw[SW-1]};
  assign rhs = {rh, nh[SW-1]};
  logic [SW:0] dw, dh;
  assign dw = rws - {1'b0, tw};
  assign dh = rhs - {1'b0, th};

  assign stat = '{div_done: div_done, clr_done: clr_done};

  logic [SW-1:0] bw, bh;
  logic [AW-1:0] area;
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt <= '0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
        dcnt <= '0;
        nw <= iw; nh <= ih; rw <= '0; rh <= '0; qw <= '0; qh <= '0;
      end else if (dbusy) begin
        nw <= {nw[SW-2:0], 1'b0};
        nh <= {nh[SW-2:0], 1'b0};
        if (!dw[SW]) begin rw <= dw[SW-1:0]; qw <= {qw[SW-2:0], 1'b1}; end
        else begin rw <= rws[SW-1:0]; qw <= {qw[SW-2:0], 1'b0}; end
        if (!dh[SW]) begin rh <= dh[SW-1:0]; qh <= {qh[SW-2:0], 1'b1}; end
        else begin rh <= rhs[SW-1:0]; qh <= {qh[SW-2:0], 1'b0}; end
        dcnt <= dcnt + 1'b1;
        if (dcnt == ($clog2(SW+1))'(SW-1)) begin
          dbusy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end
  // block size is registered from the quotient, then area is registered from the block size
  always_ff @(posedge clk) begin
    bw <= (qw == '0) ? SW'(1) : qw;
    bh <= (qh == '0) ? SW'(1) : qh;
    area <= AW'(bw * bh);
  end

  // clear sweep
  logic [CW:0] ccnt;
  logic cbusy;
  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      ccnt <= '0;
      clr_done <= 1'b0;
    end else begin
      clr_done <= 1'b0;
      if (cmd.clr_start) begin
        cbusy <= 1'b1;
        ccnt <= '0;
      end else if (cbusy && !dbusy && !cmd.div_start) begin
        ccnt <= ccnt + 1'b1;
        if (ccnt == (CW+1)'(DEPTH-1)) begin
          cbusy <= 1'b0;
          clr_done <= 1'b1;
        end
      end
    end
  end

  // position counters, sub-block counters, output column
  logic [SW-1:0] col, row, bcol, brow, oc, orow;
  logic [SW+SW-1:0] lim_c, lim_r;
  always_ff @(posedge clk) begin
    lim_c <= ow * bw;
    lim_r <= oh * bh;
  end

  // pipeline: stage A read, stage B add/write, stage C divide
  logic a_vld, a_emit, a_last;
  logic [CW-1:0] a_oc;
  logic [7:0] a_r, a_g, a_b, a_a;
  logic [4*SUMW-1:0] mem [DEPTH];
  logic [4*SUMW-1:0] rd;

  logic busy_div;
  logic b_full;
  logic b_last;
  logic [QW-1:0] q_r, q_g, q_b, q_a;
  logic [$clog2(SUMW+1)-1:0] bcnt;
  logic [SUMW-1:0] rem_r, rem_g, rem_b, rem_a;
  logic [SUMW-1:0] num_r, num_g, num_b, num_a;
  logic out_vld;

  // one item at a time in the pipe; divider gates acceptance
  assign pix.ready = run && !a_vld && !b_full && !busy_div && !out_vld;
  logic acc;
  assign acc = pix.valid && pix.ready;

  logic in_blk, emit;
  assign in_blk = ({{SW{1'b0}}, col} < lim_c) && ({{SW{1'b0}}, row} < lim_r);
  assign emit = in_blk && (bcol == bw - 1'b1) && (brow == bh - 1'b1);

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      col <= '0; row <= '0; bcol <= '0; brow <= '0; oc <= '0; orow <= '0;
    end else if (acc) begin
      if (col + 1'b1 >= iw) begin
        col <= '0; bcol <= '0; oc <= '0;
        if (row + 1'b1 >= ih) begin
          row <= '0; brow <= '0; orow <= '0;
        end else begin
          row <= row + 1'b1;
          if (brow == bh - 1'b1) begin brow <= '0; orow <= orow + 1'b1; end
          else brow <= brow + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
        if (bcol == bw - 1'b1) begin bcol <= '0; oc <= oc + 1'b1; end
        else bcol <= bcol + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) a_vld <= 1'b0;
    else a_vld <= acc && in_blk;
    a_oc <= oc[CW-1:0];
    a_emit <= emit;
    a_last <= (oc == ow - 1'b1) && (orow == oh - 1'b1);
    a_r <= pix.pix_red; a_g <= pix.pix_green; a_b <= pix.pix_blue;
    a_a <= alpha_mode ? pix.pix_alpha : 8'd0;
  end

  always_ff @(posedge clk) begin
    rd <= mem[oc[CW-1:0]];
  end

  logic [SUMW-1:0] n_r, n_g, n_b, n_a;
  assign n_r = rd[4*SUMW-1:3*SUMW] + SUMW'(a_r);
  assign n_g = rd[3*SUMW-1:2*SUMW] + SUMW'(a_g);
  assign n_b = rd[2*SUMW-1:SUMW] + SUMW'(a_b);
  assign n_a = rd[SUMW-1:0] + SUMW'(a_a);

  always_ff @(posedge clk) begin
    if (cbusy) mem[ccnt[CW-1:0]] <= '0;
    else if (a_vld) mem[a_oc] <= a_emit ? '0 : {n_r, n_g, n_b, n_a};
  end

  // serial restoring divide of four sums by area, low 8 quotient bits kept
  logic [SUMW:0] t_r, t_g, t_b, t_a;
  assign t_r = {rem_r, num_r[SUMW-1]} - {{(SUMW+1-AW){1'b0}}, area};
  assign t_g = {rem_g, num_g[SUMW-1]} - {{(SUMW+1-AW){1'b0}}, area};
  assign t_b = {rem_b, num_b[SUMW-1]} - {{(SUMW+1-AW){1'b0}}, area};
  assign t_a = {rem_a, num_a[SUMW-1]} - {{(SUMW+1-AW){1'b0}}, area};

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      b_full <= 1'b0;
      busy_div <= 1'b0;
      out_vld <= 1'b0;
      bcnt <= '0;
    end else begin
      if (a_vld && a_emit) begin
        b_full <= 1'b1;
        busy_div <= 1'b1;
        bcnt <= '0;
        num_r <= n_r; num_g <= n_g; num_b <= n_b; num_a <= n_a;
        rem_r <= '0; rem_g <= '0; rem_b <= '0; rem_a <= '0;
        b_last <= a_last;
      end else if (busy_div) begin
        num_r <= {num_r[SUMW-2:0], 1'b0};
        num_g <= {num_g[SUMW-2:0], 1'b0};
        num_b <= {num_b[SUMW-2:0], 1'b0};
        num_a <= {num_a[SUMW-2:0], 1'b0};
        rem_r <= t_r[SUMW] ? {rem_r[SUMW-2:0], num_r[SUMW-1]} : t_r[SUMW-1:0];
        rem_g <= t_g[SUMW] ? {rem_g[SUMW-2:0], num_g[SUMW-1]} : t_g[SUMW-1:0];
        rem_b <= t_b[SUMW] ? {rem_b[SUMW-2:0], num_b[SUMW-1]} : t_b[SUMW-1:0];
        rem_a <= t_a[SUMW] ? {rem_a[SUMW-2:0], num_a[SUMW-1]} : t_a[SUMW-1:0];
        q_r <= {q_r[QW-2:0], ~t_r[SUMW]};
        q_g <= {q_g[QW-2:0], ~t_g[SUMW]};
        q_b <= {q_b[QW-2:0], ~t_b[SUMW]};
        q_a <= {q_a[QW-2:0], ~t_a[SUMW]};
        bcnt <= bcnt + 1'b1;
        if (bcnt == ($clog2(SUMW+1))'(SUMW-1)) begin
          busy_div <= 1'b0;
          b_full <= 1'b0;
          out_vld <= 1'b1;
        end
      end
      if (avg.valid && avg.ready) out_vld <= 1'b0;
    end
  end

  assign avg.valid = out_vld;
  assign avg.avg_red = q_r;
  assign avg.avg_green = q_g;
  assign avg.avg_blue = q_b;
  assign avg.avg_alpha = alpha_mode ? q_a : 8'd0;
  assign avg.frame_last = b_last;
endmodule

FILE: rtl/box_average_image_downscaler_top.sv
// Top level of the box average image downscaler.
`timescale 1ns / 1ps
// channel | role | words
// pix     | sink   | one input pixel, raster order
// avg     | source | one block average, frame_last on the final one
// cfg     | write  | register index and data, no back-pressure
// A pixel inside a block is read from the column sum memory and written back,
// and input waits for the write-back; a dropped pixel does not hold input. A
// pixel that completes a block holds input while the bit-serial divider works
// out the means. After reset or a write to a defined register, the block-size
// division runs, then the column sum memory is cleared, before the first pixel.
// A stalled result blocks further input until it is taken.
module box_average_image_downscaler_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [bad_pkg::SW-1:0] cfg_data,
  bad_pix_if.sink pix,
  bad_avg_if.source avg
);
  bad_pkg::cmd_t cmd;
  bad_pkg::stat_t stat;
  logic run;
  logic cfg_hit;

  // only writes to a defined register restart the frame
  assign cfg_hit = cfg_we && (cfg_index <= bad_pkg::REG_ALPHA_MODE);

  bad_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cfg_write(cfg_hit), .stat(stat), .cmd(cmd), .run(run)
  );

  bad_dp u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .stat(stat), .run(run), .pix(pix), .avg(avg)
  );
endmodule
